>>> src/pwm_capture_measure_defines.svh
// Assertion macros shared by the blocks of pwm_capture_measure.
// Both sample on the rising clock edge and are quiet while in reset.
`ifndef PWM_CAPTURE_MEASURE_DEFINES_SVH
`define PWM_CAPTURE_MEASURE_DEFINES_SVH

`define PCM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define PCM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/pcm_pkg.sv
package pcm_pkg;

  localparam int unsigned TIME_IN_W = 16;
  localparam int unsigned FREQ_W    = 24;
  localparam int unsigned DUTY_W    = 7;
  localparam int unsigned STATUS_W  = 2;

  localparam logic [FREQ_W-1:0] TICK_RESET = 24'd1000000;
  localparam logic [DUTY_W-1:0] PERCENT    = 7'd100;

  localparam logic MODE_ARM     = 1'b0;
  localparam logic MODE_CAPTURE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;

  typedef struct packed {
    logic                 mode;
    logic [TIME_IN_W-1:0] capture_time;
  } pcm_in_t;

  typedef struct packed {
    logic                expect_rising;
    logic                done_res;
    logic [FREQ_W-1:0]   freq_hz;
    logic [DUTY_W-1:0]   duty_percent;
    logic [STATUS_W-1:0] status;
  } pcm_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load_rise;
    logic load_fall;
    logic setup;
    logic div_load_duty;
    logic div_load_freq;
    logic div_step;
    logic save_duty;
    logic out_load;
    logic out_done;
    logic out_expect;
  } pcm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic period_zero;
    logic div_last;
  } pcm_sts_t;

endpackage

>>> src/pcm_ctrl.sv
`include "pwm_capture_measure_defines.svh"

module pcm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              in_mode_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pcm_pkg::pcm_cmd_t cmd_o,
  input  pcm_pkg::pcm_sts_t sts_i
);
  import pcm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_DUTY_LD = 6'b000010,
    S_DUTY    = 6'b000100,
    S_FREQ_LD = 6'b001000,
    S_FREQ    = 6'b010000,
    S_HOLD    = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    PH_RISE1 = 2'd0,
    PH_FALL  = 2'd1,
    PH_RISE2 = 2'd2,
    PH_IDLE  = 2'd3
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   in_acc;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    out_free    = !out_valid_q || !out_stall_i;
    in_stall_o  = !((state_q == S_IDLE) && out_free);
    in_acc      = in_valid_i && !in_stall_o;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_mode_i == MODE_ARM) begin
            phase_d          = PH_RISE1;
            cmd_o.out_load   = 1'b1;
            cmd_o.out_expect = 1'b1;
          end else begin
            case (phase_q)
              PH_RISE1: begin
                cmd_o.load_rise  = 1'b1;
                phase_d          = PH_FALL;
                cmd_o.out_load   = 1'b1;
                cmd_o.out_expect = 1'b0;
              end
              PH_FALL: begin
                cmd_o.load_fall  = 1'b1;
                phase_d          = PH_RISE2;
                cmd_o.out_load   = 1'b1;
                cmd_o.out_expect = 1'b1;
              end
              PH_RISE2: begin
                cmd_o.setup = 1'b1;
                phase_d     = PH_IDLE;
                state_d     = S_DUTY_LD;
              end
              default: begin
                // idle: capture dropped
                cmd_o.out_load   = 1'b1;
                cmd_o.out_expect = 1'b1;
              end
            endcase
          end
        end
      end
      S_DUTY_LD: begin
        if (sts_i.period_zero) begin
          state_d = S_HOLD;
        end else begin
          cmd_o.div_load_duty = 1'b1;
          state_d             = S_DUTY;
        end
      end
      S_DUTY: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_FREQ_LD;
        end
      end
      S_FREQ_LD: begin
        cmd_o.save_duty     = 1'b1;
        cmd_o.div_load_freq = 1'b1;
        state_d             = S_FREQ;
      end
      S_FREQ: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_done   = 1'b1;
          cmd_o.out_expect = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `PCM_ASSERT(a_state_onehot, $onehot(state_q), "controller state not one-hot")
  `PCM_ASSERT(a_load_free, !cmd_o.out_load || out_free, "result loaded over a held beat")
  `PCM_ASSERT_NEXT(a_third_edge, in_acc && in_mode_i == MODE_CAPTURE && phase_q == PH_RISE2,
    state_q == S_DUTY_LD && phase_q == PH_IDLE, "third capture did not start the sums")
  `PCM_ASSERT_NEXT(a_duty_to_freq, state_q == S_DUTY && sts_i.div_last,
    state_q == S_FREQ_LD, "duty division did not hand over to frequency")

endmodule

>>> src/pcm_dp.sv
module pcm_dp #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pcm_pkg::pcm_in_t             in_data_i,
  input  logic                         cfg_we_i,
  input  logic [pcm_pkg::FREQ_W-1:0]   cfg_wdata_i,
  input  pcm_pkg::pcm_cmd_t            cmd_i,
  output pcm_pkg::pcm_sts_t            sts_o,
  output pcm_pkg::pcm_out_t            out_data_o
);
  import pcm_pkg::*;

  // high*100 needs 7 bits above the time width
  localparam int unsigned PW = TIME_BITS + 7;
  localparam int unsigned QW = (PW > FREQ_W) ? PW : FREQ_W;
  localparam int unsigned CW = $clog2(QW + 1);

  logic [FREQ_W-1:0]    tick_q;
  logic [TIME_BITS-1:0] rise_q, fall_q, period_q;
  logic [PW-1:0]        prod_q;
  logic [QW-1:0]        dvd_q;
  logic [TIME_BITS-1:0] rem_q;
  logic [CW-1:0]        cnt_q;
  logic [DUTY_W-1:0]    duty_q;
  logic                 sat_q, zero_q;
  pcm_out_t             out_q, out_d;

  logic [TIME_BITS-1:0] t_in, high;
  logic [PW-1:0]        hx, prod;
  logic [TIME_BITS:0]   trial, diff;
  logic                 ge;
  logic [PW-1:0]        q_duty;
  logic                 q_sat;

  assign t_in = TIME_BITS'(in_data_i.capture_time);
  assign high = fall_q - rise_q;
  assign hx   = PW'(high);
  assign prod = (hx << 6) + (hx << 5) + (hx << 2);

  // restoring division, one quotient bit per step
  assign trial = {rem_q, dvd_q[QW-1]};
  assign ge    = trial >= {1'b0, period_q};
  assign diff  = trial - {1'b0, period_q};

  assign q_duty = dvd_q[PW-1:0];
  assign q_sat  = q_duty > PW'(PERCENT);

  assign sts_o = '{period_zero: (period_q == '0), div_last: (cnt_q == CW'(1))};

  // result beat assembled from the command bits
  always_comb begin
    out_d               = '0;
    out_d.expect_rising = cmd_i.out_expect;
    if (cmd_i.out_done) begin
      out_d.done_res = 1'b1;
      if (zero_q) begin
        out_d.status = STATUS_ZERO;
      end else begin
        out_d.freq_hz      = dvd_q[FREQ_W-1:0];
        out_d.duty_percent = duty_q;
        out_d.status       = sat_q ? STATUS_SAT : STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= TICK_RESET;
      cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        tick_q <= cfg_wdata_i;
      end
      if (cmd_i.div_load_duty) begin
        cnt_q <= CW'(PW);
      end else if (cmd_i.div_load_freq) begin
        cnt_q <= CW'(FREQ_W);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rise) begin
      rise_q <= t_in;
    end
    if (cmd_i.load_fall) begin
      fall_q <= t_in;
    end
    if (cmd_i.setup) begin
      period_q <= t_in - rise_q;
      prod_q   <= prod;
      zero_q   <= (t_in == rise_q);
    end
    if (cmd_i.div_load_duty) begin
      dvd_q <= QW'(prod_q) << (QW - PW);
      rem_q <= '0;
    end else if (cmd_i.div_load_freq) begin
      dvd_q <= QW'(tick_q) << (QW - FREQ_W);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
      dvd_q <= {dvd_q[QW-2:0], ge};
    end
    if (cmd_i.save_duty) begin
      sat_q  <= q_sat;
      duty_q <= q_sat ? PERCENT : q_duty[DUTY_W-1:0];
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> src/pwm_capture_measure.sv
// Arm and non-final captures give their result beat in the cycle after acceptance.
// The third capture runs one shared restoring divider (1 bit a cycle), duty then frequency,
// skipping both divisions on zero period; the result beat then waits for a free output.
// One item at a time: a new item is taken only while idle and once the result register is free.
// Reset (rst_ni low, asynchronous): idle until armed, tick rate 1000000, no result pending.
module pwm_capture_measure #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // item in
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  pcm_pkg::pcm_in_t           in_data_i,
  // result out
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output pcm_pkg::pcm_out_t          out_data_o,
  // tick rate register
  input  logic                       cfg_we_i,
  input  logic [pcm_pkg::FREQ_W-1:0] cfg_wdata_i
);
  import pcm_pkg::*;

  // Controller owns the edge phase (rise, fall, rise, idle), the sequencing
  // of the two divisions and the output beat valid. The datapath holds the
  // timestamps, period and high*100, the divider and the result register.
  pcm_cmd_t cmd;
  pcm_sts_t sts;

  pcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_mode_i   (in_data_i.mode),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Duty = high*100/period, saturated at 100; freq = tick/period.
  // Period and high time wrap modulo 2^TIME_BITS.
  pcm_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule
